// ===== hdl/avo_pkg.sv =====
// attitude vector observer: shared types, constants and micro-op program
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package avo_pkg;

    localparam int FRAC_BITS = 16;
    localparam int GAIN_BITS = 16;
    localparam int VEC_W = 32;
    localparam int GAIN_W = 16;
    localparam int MIN_SHIFT = (FRAC_BITS < GAIN_BITS) ? FRAC_BITS : GAIN_BITS;
    localparam int ACC_W = 2 * VEC_W + 2 - MIN_SHIFT;
    localparam int OPA_W = VEC_W + 1;
    localparam int PROD_W = 2 * VEC_W;
    localparam int DT_Q = int'(((64'(5) << FRAC_BITS) + 64'(500)) / 64'(1000));
    localparam int REQ_W = 3;
    localparam int STEP_W = 4;
    localparam int IN_DATA_W = 3 * VEC_W;
    localparam int OUT_DATA_W = 6 * VEC_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [GAIN_W-1:0] ACCEL_GAIN_RESET = 16'd216;
    localparam logic [GAIN_W-1:0] MAGNET_GAIN_RESET = 16'd6554;
    localparam logic REG_ACCEL_GAIN = 1'b0;
    localparam logic REG_MAGNET_GAIN = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_GYRO       = 3'd0,
        REQ_ACCEL      = 3'd1,
        REQ_MAGNET     = 3'd2,
        REQ_LOAD_GRAV  = 3'd3,
        REQ_LOAD_FIELD = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        A_DT, A_W0, A_W1, A_W2, A_KEEP_ACC, A_GAIN_ACC, A_KEEP_MAG, A_GAIN_MAG
    } t_asel;

    typedef enum logic [3:0] {
        B_V0, B_V1, B_V2, B_G0, B_G1, B_G2, B_F0, B_F1, B_F2
    } t_bsel;

    typedef enum logic [2:0] {
        BASE_ZERO, BASE_G0, BASE_G1, BASE_G2, BASE_F0, BASE_F1, BASE_F2
    } t_base;

    typedef enum logic [3:0] {
        D_W0, D_W1, D_W2, D_TG0, D_TG1, D_TG2, D_TF0, D_TF1, D_TF2
    } t_dst;

    typedef struct packed {
        t_asel a;
        t_bsel b;
        logic  first;
        logic  sub;
        t_base base;
        logic  last;
        t_dst  dst;
    } t_uop;

    typedef struct packed {
        logic g_from_t;
        logic f_from_t;
        logic g_from_v;
        logic f_from_v;
    } t_commit;

    typedef struct packed {
        logic    capture;
        logic    issue;
        t_uop    uop;
        logic    commit;
        t_commit sel;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

    function automatic t_uop mk_uop(t_asel a, t_bsel b, logic first, logic sub,
                                    t_base base, logic last, t_dst dst);
        t_uop u;
        u.a = a;
        u.b = b;
        u.first = first;
        u.sub = sub;
        u.base = base;
        u.last = last;
        u.dst = dst;
        return u;
    endfunction

    // small-angle rotation of one vector, two products per component
    function automatic t_uop rot_uop(logic fld, logic [2:0] k);
        t_bsel s0, s1, s2;
        t_base c0, c1, c2;
        t_dst  d0, d1, d2;
        t_uop  u;
        s0 = fld ? B_F0 : B_G0;
        s1 = fld ? B_F1 : B_G1;
        s2 = fld ? B_F2 : B_G2;
        c0 = fld ? BASE_F0 : BASE_G0;
        c1 = fld ? BASE_F1 : BASE_G1;
        c2 = fld ? BASE_F2 : BASE_G2;
        d0 = fld ? D_TF0 : D_TG0;
        d1 = fld ? D_TF1 : D_TG1;
        d2 = fld ? D_TF2 : D_TG2;
        case (k)
            3'd0:    u = mk_uop(A_W0, s2, 1'b1, 1'b0, c1, 1'b0, d1);
            3'd1:    u = mk_uop(A_W2, s0, 1'b0, 1'b1, c1, 1'b1, d1);
            3'd2:    u = mk_uop(A_W2, s1, 1'b1, 1'b0, c0, 1'b0, d0);
            3'd3:    u = mk_uop(A_W1, s2, 1'b0, 1'b1, c0, 1'b1, d0);
            3'd4:    u = mk_uop(A_W1, s0, 1'b1, 1'b0, c2, 1'b0, d2);
            3'd5:    u = mk_uop(A_W0, s1, 1'b0, 1'b1, c2, 1'b1, d2);
            default: u = mk_uop(A_DT, B_V0, 1'b1, 1'b0, BASE_ZERO, 1'b0, D_W0);
        endcase
        return u;
    endfunction

    // s*(1-k) then k*m, per component
    function automatic t_uop blend_uop(logic fld, logic [STEP_W-1:0] step);
        t_bsel s, m;
        t_dst  d;
        t_uop  u;
        case (step[2:1])
            2'd0:    begin s = fld ? B_F0 : B_G0; m = B_V0; d = fld ? D_TF0 : D_TG0; end
            2'd1:    begin s = fld ? B_F1 : B_G1; m = B_V1; d = fld ? D_TF1 : D_TG1; end
            default: begin s = fld ? B_F2 : B_G2; m = B_V2; d = fld ? D_TF2 : D_TG2; end
        endcase
        if (!step[0]) begin
            u = mk_uop(fld ? A_KEEP_MAG : A_KEEP_ACC, s, 1'b1, 1'b0, BASE_ZERO, 1'b0, d);
        end else begin
            u = mk_uop(fld ? A_GAIN_MAG : A_GAIN_ACC, m, 1'b0, 1'b0, BASE_ZERO, 1'b1, d);
        end
        return u;
    endfunction

    function automatic logic [STEP_W-1:0] avo_len(logic [REQ_W-1:0] kind);
        logic [STEP_W-1:0] n;
        case (kind)
            REQ_GYRO:   n = 4'd15;
            REQ_ACCEL:  n = 4'd6;
            REQ_MAGNET: n = 4'd6;
            default:    n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic t_uop avo_uop(logic [REQ_W-1:0] kind, logic [STEP_W-1:0] step);
        t_uop u;
        case (kind)
            REQ_GYRO: begin
                case (step)
                    4'd0:    u = mk_uop(A_DT, B_V0, 1'b1, 1'b0, BASE_ZERO, 1'b1, D_W0);
                    4'd1:    u = mk_uop(A_DT, B_V1, 1'b1, 1'b0, BASE_ZERO, 1'b1, D_W1);
                    4'd2:    u = mk_uop(A_DT, B_V2, 1'b1, 1'b0, BASE_ZERO, 1'b1, D_W2);
                    default: begin
                        if (step < 4'd9) begin
                            u = rot_uop(1'b0, 3'(step - 4'd3));
                        end else begin
                            u = rot_uop(1'b1, 3'(step - 4'd9));
                        end
                    end
                endcase
            end
            REQ_ACCEL:  u = blend_uop(1'b0, step);
            REQ_MAGNET: u = blend_uop(1'b1, step);
            default:    u = mk_uop(A_DT, B_V0, 1'b1, 1'b0, BASE_ZERO, 1'b0, D_W0);
        endcase
        return u;
    endfunction

    function automatic t_commit avo_commit_sel(logic [REQ_W-1:0] kind);
        t_commit c;
        c = '0;
        case (kind)
            REQ_GYRO:       begin c.g_from_t = 1'b1; c.f_from_t = 1'b1; end
            REQ_ACCEL:      c.g_from_t = 1'b1;
            REQ_MAGNET:     c.f_from_t = 1'b1;
            REQ_LOAD_GRAV:  c.g_from_v = 1'b1;
            REQ_LOAD_FIELD: c.f_from_v = 1'b1;
            default:        c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/avo_ctrl.sv =====
// attitude vector observer controller: sequences micro-ops per request
// depends on avo_pkg
`timescale 1ns / 1ps
`default_nettype none

module avo_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [avo_pkg::REQ_W-1:0]  i_req_type,
    output logic                            o_in_ready,
    input  wire avo_pkg::t_status           i_status,
    output avo_pkg::t_cmd                   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [avo_pkg::STEP_W-1:0]  r_step, n_step;
    logic [avo_pkg::REQ_W-1:0]   r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        n_kind = r_kind;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_kind = i_req_type;
                    n_step = '0;
                    n_state = (avo_pkg::avo_len(i_req_type) == '0) ? ST_COMMIT : ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                o_cmd.uop = avo_pkg::avo_uop(r_kind, r_step);
                if (r_step == avo_pkg::avo_len(r_kind) - 4'd1) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.sel = avo_pkg::avo_commit_sel(r_kind);
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step <= '0;
            r_kind <= '0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_kind <= n_kind;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/avo_datapath.sv =====
// attitude vector observer datapath: shared multiplier, accumulator with
// saturation, vector state and output register; depends on avo_pkg
`timescale 1ns / 1ps
`default_nettype none

module avo_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire avo_pkg::t_cmd                   i_cmd,
    output avo_pkg::t_status                     o_status,
    input  wire logic [avo_pkg::IN_DATA_W-1:0]   i_vec,
    input  wire logic [avo_pkg::GAIN_W-1:0]      i_accel_gain,
    input  wire logic [avo_pkg::GAIN_W-1:0]      i_magnet_gain,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [avo_pkg::OUT_DATA_W-1:0]       o_out_data
);

    localparam int VW = avo_pkg::VEC_W;
    localparam int AW = avo_pkg::ACC_W;

    logic [VW-1:0] r_v [3];
    logic [VW-1:0] r_g [3];
    logic [VW-1:0] r_f [3];
    logic [VW-1:0] r_w [3];
    logic [VW-1:0] r_t [6];
    logic [VW-1:0] n_g [3];
    logic [VW-1:0] n_f [3];

    logic signed [avo_pkg::PROD_W-1:0] r_prod;
    logic                              r_gshift;
    logic                              r_acc_vld;
    avo_pkg::t_uop                     r_acc_uop;
    logic signed [AW-1:0]              r_acc;

    logic                              r_out_valid;
    logic [avo_pkg::OUT_DATA_W-1:0]    r_out_data;

    logic signed [avo_pkg::OPA_W-1:0]  w_a;
    logic signed [VW-1:0]              w_b;
    logic signed [avo_pkg::PROD_W:0]   w_prod;
    logic [avo_pkg::GAIN_W:0]          w_keep_acc, w_keep_mag;
    logic                              w_gshift;

    logic [VW-1:0]                     w_base;
    logic signed [avo_pkg::PROD_W-1:0] w_sh;
    logic signed [AW-1:0]              w_term, w_lhs, w_acc_next;
    logic [VW-1:0]                     w_sat;

    // multiply stage
    assign w_keep_acc = (17'd1 << avo_pkg::GAIN_BITS) - {1'b0, i_accel_gain};
    assign w_keep_mag = (17'd1 << avo_pkg::GAIN_BITS) - {1'b0, i_magnet_gain};

    always_comb begin
        w_gshift = 1'b0;
        case (i_cmd.uop.a)
            avo_pkg::A_DT:       w_a = avo_pkg::OPA_W'(avo_pkg::DT_Q);
            avo_pkg::A_W0:       w_a = {r_w[0][VW-1], r_w[0]};
            avo_pkg::A_W1:       w_a = {r_w[1][VW-1], r_w[1]};
            avo_pkg::A_W2:       w_a = {r_w[2][VW-1], r_w[2]};
            avo_pkg::A_KEEP_ACC: begin
                w_a = avo_pkg::OPA_W'(w_keep_acc);
                w_gshift = 1'b1;
            end
            avo_pkg::A_GAIN_ACC: begin
                w_a = avo_pkg::OPA_W'(i_accel_gain);
                w_gshift = 1'b1;
            end
            avo_pkg::A_KEEP_MAG: begin
                w_a = avo_pkg::OPA_W'(w_keep_mag);
                w_gshift = 1'b1;
            end
            avo_pkg::A_GAIN_MAG: begin
                w_a = avo_pkg::OPA_W'(i_magnet_gain);
                w_gshift = 1'b1;
            end
            default:             w_a = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.uop.b)
            avo_pkg::B_V0: w_b = r_v[0];
            avo_pkg::B_V1: w_b = r_v[1];
            avo_pkg::B_V2: w_b = r_v[2];
            avo_pkg::B_G0: w_b = r_g[0];
            avo_pkg::B_G1: w_b = r_g[1];
            avo_pkg::B_G2: w_b = r_g[2];
            avo_pkg::B_F0: w_b = r_f[0];
            avo_pkg::B_F1: w_b = r_f[1];
            avo_pkg::B_F2: w_b = r_f[2];
            default:       w_b = '0;
        endcase
    end

    assign w_prod = w_a * w_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod[avo_pkg::PROD_W-1:0];
        r_gshift <= w_gshift;
        r_acc_uop <= i_cmd.uop;
    end

    // accumulate stage
    always_comb begin
        case (r_acc_uop.base)
            avo_pkg::BASE_G0: w_base = r_g[0];
            avo_pkg::BASE_G1: w_base = r_g[1];
            avo_pkg::BASE_G2: w_base = r_g[2];
            avo_pkg::BASE_F0: w_base = r_f[0];
            avo_pkg::BASE_F1: w_base = r_f[1];
            avo_pkg::BASE_F2: w_base = r_f[2];
            default:          w_base = '0;
        endcase
    end

    assign w_sh = r_gshift ? (r_prod >>> avo_pkg::GAIN_BITS) : (r_prod >>> avo_pkg::FRAC_BITS);
    assign w_term = w_sh[AW-1:0];
    assign w_lhs = r_acc_uop.first ? {{(AW-VW){w_base[VW-1]}}, w_base} : r_acc;
    assign w_acc_next = r_acc_uop.sub ? (w_lhs - w_term) : (w_lhs + w_term);

    always_comb begin
        if ((&w_acc_next[AW-1:VW-1]) || !(|w_acc_next[AW-1:VW-1])) begin
            w_sat = w_acc_next[VW-1:0];
        end else if (w_acc_next[AW-1]) begin
            w_sat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(VW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= 1'b0;
        end else begin
            r_acc_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_acc_vld) begin
            r_acc <= w_acc_next;
            if (r_acc_uop.last) begin
                case (r_acc_uop.dst)
                    avo_pkg::D_W0:  r_w[0] <= w_sat;
                    avo_pkg::D_W1:  r_w[1] <= w_sat;
                    avo_pkg::D_W2:  r_w[2] <= w_sat;
                    avo_pkg::D_TG0: r_t[0] <= w_sat;
                    avo_pkg::D_TG1: r_t[1] <= w_sat;
                    avo_pkg::D_TG2: r_t[2] <= w_sat;
                    avo_pkg::D_TF0: r_t[3] <= w_sat;
                    avo_pkg::D_TF1: r_t[4] <= w_sat;
                    avo_pkg::D_TF2: r_t[5] <= w_sat;
                    default:        r_t[0] <= r_t[0];
                endcase
            end
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_v[0] <= i_vec[VW-1:0];
            r_v[1] <= i_vec[2*VW-1:VW];
            r_v[2] <= i_vec[3*VW-1:2*VW];
        end
    end

    // state commit
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.sel.g_from_t) begin
                n_g[i] = r_t[i];
            end else if (i_cmd.sel.g_from_v) begin
                n_g[i] = r_v[i];
            end else begin
                n_g[i] = r_g[i];
            end
            if (i_cmd.sel.f_from_t) begin
                n_f[i] = r_t[i+3];
            end else if (i_cmd.sel.f_from_v) begin
                n_f[i] = r_v[i];
            end else begin
                n_f[i] = r_f[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_g[i] <= '0;
                r_f[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < 3; i++) begin
                r_g[i] <= n_g[i];
                r_f[i] <= n_f[i];
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {n_f[2], n_f[1], n_f[0], n_g[2], n_g[1], n_g[0]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

// ===== hdl/attitude_vector_observer.sv =====
// attitude vector observer top level: stream ports, config registers,
// controller and datapath; depends on avo_pkg, avo_ctrl, avo_datapath
// an accepted word goes through RUN, which issues the micro-ops of its kind,
// then DRAIN and COMMIT; a load or unused kind goes straight to COMMIT; one
// shared 33x32 multiplier issues one product per cycle in RUN, and
// the input side accepts the next word while a finished result waits
// synchronous active-low reset clears both vectors and restores the gains
`timescale 1ns / 1ps
`default_nettype none

module attitude_vector_observer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [avo_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // vec_x, vec_y, vec_z
    input  wire logic [avo_pkg::REQ_W-1:0]          s_axis_tuser,   // req_type
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // grav_x, grav_y, grav_z, field_x, field_y, field_z
    output logic [avo_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [avo_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [avo_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [avo_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready
);

    logic [avo_pkg::GAIN_W-1:0] r_accel_gain;
    logic [avo_pkg::GAIN_W-1:0] r_magnet_gain;
    logic                       w_reg_idx;
    avo_pkg::t_cmd              w_cmd;
    avo_pkg::t_status           w_status;

    assign pready = 1'b1;
    assign w_reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_gain <= avo_pkg::ACCEL_GAIN_RESET;
            r_magnet_gain <= avo_pkg::MAGNET_GAIN_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg_idx)
                avo_pkg::REG_ACCEL_GAIN:  r_accel_gain <= pwdata[avo_pkg::GAIN_W-1:0];
                avo_pkg::REG_MAGNET_GAIN: r_magnet_gain <= pwdata[avo_pkg::GAIN_W-1:0];
                default:                  r_accel_gain <= r_accel_gain;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            avo_pkg::REG_ACCEL_GAIN:  prdata = avo_pkg::APB_DATA_W'(r_accel_gain);
            avo_pkg::REG_MAGNET_GAIN: prdata = avo_pkg::APB_DATA_W'(r_magnet_gain);
            default:                  prdata = '0;
        endcase
    end

    avo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    avo_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_vec         (s_axis_tdata),
        .i_accel_gain  (r_accel_gain),
        .i_magnet_gain (r_magnet_gain),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/sv/avo_result_check.sv =====
// attitude vector observer checker: follows the config port and both streams,
// predicts every result word from its own copy of the state and compares it
// field by field; depends on avo_pkg
`timescale 1ns / 1ps

module avo_result_check
    import avo_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      s_axis_tvalid,
    input  wire logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]      s_axis_tdata,   // vec_x, vec_y, vec_z
    input  wire logic [REQ_W-1:0]          s_axis_tuser,   // req_type
    input  wire logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // grav_x, grav_y, grav_z, field_x, field_y, field_z
    input  wire logic [OUT_DATA_W-1:0]     m_axis_tdata,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_W-1:0]     paddr,
    input  wire logic [APB_DATA_W-1:0]     pwdata,
    input  wire logic [APB_DATA_W-1:0]     prdata,
    input  wire logic                      pready,
    output int                             o_mismatches,
    output int                             o_pending
);

    localparam logic [APB_ADDR_W-1:0] ADDR_ACCEL_GAIN = {REG_ACCEL_GAIN, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_MAGNET_GAIN = {REG_MAGNET_GAIN, 2'b00};
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam longint GAIN_ONE = 64'sd1 <<< GAIN_BITS;

    typedef logic [3*VEC_W-1:0] t_vec3;

    t_vec3                 grav_est;
    t_vec3                 field_est;
    logic [GAIN_W-1:0]     accel_k;
    logic [GAIN_W-1:0]     magnet_k;
    logic [OUT_DATA_W-1:0] results_due [$];
    int                    mismatches = 0;
    string                 field_label [6] = '{"grav_x", "grav_y", "grav_z",
                                               "field_x", "field_y", "field_z"};

    assign o_mismatches = mismatches;

    function automatic longint lane(t_vec3 v, int i);
        return longint'($signed(v[i*VEC_W +: VEC_W]));
    endfunction

    function automatic longint clamp_word(longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // exact product, then floor shift
    function automatic longint fix_mul(longint a, longint b, int shift);
        return (a * b) >>> shift;
    endfunction

    function automatic t_vec3 pack_vec(longint x, longint y, longint z);
        return {VEC_W'(clamp_word(z)), VEC_W'(clamp_word(y)), VEC_W'(clamp_word(x))};
    endfunction

    function automatic t_vec3 rotate_small_angle(t_vec3 s, longint w0, longint w1, longint w2);
        longint sx;
        longint sy;
        longint sz;
        sx = lane(s, 0);
        sy = lane(s, 1);
        sz = lane(s, 2);
        return pack_vec(sx + fix_mul(w2, sy, FRAC_BITS) - fix_mul(w1, sz, FRAC_BITS),
                        sy - fix_mul(w2, sx, FRAC_BITS) + fix_mul(w0, sz, FRAC_BITS),
                        sz + fix_mul(w1, sx, FRAC_BITS) - fix_mul(w0, sy, FRAC_BITS));
    endfunction

    function automatic t_vec3 blend_toward(t_vec3 s, t_vec3 m, logic [GAIN_W-1:0] k);
        longint kk;
        longint keep;
        longint r [3];
        kk = longint'(k);
        keep = GAIN_ONE - kk;
        for (int i = 0; i < 3; i++) begin
            r[i] = fix_mul(lane(s, i), keep, GAIN_BITS) + fix_mul(kk, lane(m, i), GAIN_BITS);
        end
        return pack_vec(r[0], r[1], r[2]);
    endfunction

    always @(posedge i_clk) begin : watch
        logic [OUT_DATA_W-1:0] want;
        logic [APB_DATA_W-1:0] reg_want;
        bit                    reg_known;
        t_vec3                 meas;
        longint                w [3];
        if (!i_rst_n) begin
            grav_est = '0;
            field_est = '0;
            accel_k = ACCEL_GAIN_RESET;
            magnet_k = MAGNET_GAIN_RESET;
            results_due.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr)
                        ADDR_ACCEL_GAIN:  accel_k = pwdata[GAIN_W-1:0];
                        ADDR_MAGNET_GAIN: magnet_k = pwdata[GAIN_W-1:0];
                        default: ;
                    endcase
                end else begin
                    reg_known = 1'b1;
                    reg_want = '0;
                    case (paddr)
                        ADDR_ACCEL_GAIN:  reg_want = APB_DATA_W'(accel_k);
                        ADDR_MAGNET_GAIN: reg_want = APB_DATA_W'(magnet_k);
                        default:          reg_known = 1'b0;
                    endcase
                    if (reg_known && prdata !== reg_want) begin
                        $display("%0t: prdata at %h expected %h got %h",
                                 $time, paddr, reg_want, prdata);
                        mismatches++;
                    end
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result word with none expected, expected nothing got %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (m_axis_tdata[i*VEC_W +: VEC_W] !== want[i*VEC_W +: VEC_W]) begin
                            $display("%0t: %s expected %h got %h", $time, field_label[i],
                                     want[i*VEC_W +: VEC_W], m_axis_tdata[i*VEC_W +: VEC_W]);
                            mismatches++;
                        end
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                meas = s_axis_tdata;
                case (s_axis_tuser)
                    REQ_GYRO: begin
                        for (int i = 0; i < 3; i++) begin
                            w[i] = clamp_word(fix_mul(DT_Q, lane(meas, i), FRAC_BITS));
                        end
                        grav_est = rotate_small_angle(grav_est, w[0], w[1], w[2]);
                        field_est = rotate_small_angle(field_est, w[0], w[1], w[2]);
                    end
                    REQ_ACCEL:      grav_est = blend_toward(grav_est, meas, accel_k);
                    REQ_MAGNET:     field_est = blend_toward(field_est, meas, magnet_k);
                    REQ_LOAD_GRAV:  grav_est = meas;
                    REQ_LOAD_FIELD: field_est = meas;
                    default: ;
                endcase
                results_due.push_back({field_est, grav_est});
            end
        end
        o_pending <= results_due.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// attitude vector observer testbench top: clock, reset, stream and config
// stimulus with random idling and a long output hold-off, and the verdict;
// depends on avo_pkg, attitude_vector_observer and avo_result_check
`timescale 1ns / 1ps

module tb;
    import avo_pkg::*;

    localparam int IDLE_PCT = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_WORDS = 200;
    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LAST = 3'd7;
    localparam logic [APB_ADDR_W-1:0] ADDR_ACCEL_GAIN = {REG_ACCEL_GAIN, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_MAGNET_GAIN = {REG_MAGNET_GAIN, 2'b00};
    localparam logic [VEC_W-1:0] POS_FULL = 32'h7FFF_FFFF;
    localparam logic [VEC_W-1:0] NEG_FULL = 32'h8000_0000;
    localparam logic [VEC_W-1:0] ONE_Q = 32'h0001_0000;
    localparam logic [VEC_W-1:0] MINUS_LSB = 32'hFFFF_FFFF;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [REQ_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    mismatches;
    int                    pending;
    bit                    src_steady = 1'b0;
    bit                    sink_steady = 1'b0;
    bit                    hold_pending = 1'b0;

    attitude_vector_observer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    avo_result_check checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL attitude_vector_observer");
        $finish;
    end

    // output side: random stalls, plus one long hold-off when asked
    initial begin : sink
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending && !hold_done) begin
                stall_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= sink_steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [VEC_W-1:0] pick_component();
        case ($urandom_range(9))
            0:       return POS_FULL;
            1:       return NEG_FULL;
            2, 3, 4: return $urandom();
            default: return VEC_W'($urandom_range(2097152)) - VEC_W'(1048576);
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35) return REQ_GYRO;
        if (roll < 55) return REQ_ACCEL;
        if (roll < 75) return REQ_MAGNET;
        if (roll < 85) return REQ_LOAD_GRAV;
        if (roll < 95) return REQ_LOAD_FIELD;
        return REQ_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
    endfunction

    task automatic send_word(input logic [REQ_W-1:0] kind, input logic [VEC_W-1:0] x,
                             input logic [VEC_W-1:0] y, input logic [VEC_W-1:0] z);
        bit hit;
        while (!src_steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        s_axis_tuser <= kind;
        forever begin
            @(negedge i_clk);
            hit = s_axis_tready;
            @(posedge i_clk);
            if (hit) break;
        end
    endtask

    task automatic apb_access(input bit write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] value);
        bit done;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
            if (done) break;
        end
    endtask

    task automatic set_gains(input bit write_them, input logic [APB_DATA_W-1:0] accel_word,
                             input logic [APB_DATA_W-1:0] magnet_word);
        if (write_them) begin
            apb_access(1'b1, ADDR_ACCEL_GAIN, accel_word);
            apb_access(1'b1, ADDR_MAGNET_GAIN, magnet_word);
        end
        apb_access(1'b0, ADDR_ACCEL_GAIN, '0);
        apb_access(1'b0, ADDR_MAGNET_GAIN, '0);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [APB_DATA_W-1:0] accel_word;
        logic [APB_DATA_W-1:0] magnet_word;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains read back, then directed words
        set_gains(1'b0, '0, '0);
        send_word(REQ_GYRO, POS_FULL, NEG_FULL, POS_FULL);
        send_word(REQ_LOAD_GRAV, POS_FULL, NEG_FULL, ONE_Q);
        send_word(REQ_LOAD_FIELD, NEG_FULL, POS_FULL, MINUS_LSB);
        send_word(REQ_GYRO, POS_FULL, NEG_FULL, POS_FULL);
        send_word(REQ_GYRO, '0, '0, '0);
        send_word(REQ_GYRO, ONE_Q, 32'hFFFF_8000, 32'h0002_0000);
        send_word(REQ_ACCEL, POS_FULL, NEG_FULL, '0);
        send_word(REQ_MAGNET, NEG_FULL, POS_FULL, MINUS_LSB);
        for (int k = REQ_UNUSED_FIRST; k <= REQ_UNUSED_LAST; k++) begin
            send_word(REQ_W'(k), $urandom(), $urandom(), $urandom());
        end
        send_word(REQ_LOAD_GRAV, NEG_FULL, NEG_FULL, NEG_FULL);
        send_word(REQ_ACCEL, NEG_FULL, NEG_FULL, NEG_FULL);
        send_word(REQ_LOAD_FIELD, MINUS_LSB, MINUS_LSB, MINUS_LSB);
        send_word(REQ_MAGNET, 32'h0000_0001, 32'h0000_0001, MINUS_LSB);
        send_word(REQ_LOAD_GRAV, '0, '0, ONE_Q);
        send_word(REQ_LOAD_FIELD, 32'h0000_4000, '0, 32'hFFFF_C000);
        send_word(REQ_GYRO, ONE_Q, 32'h0002_0000, 32'hFFFD_0000);
        send_word(REQ_ACCEL, '0, '0, ONE_Q);
        send_word(REQ_MAGNET, 32'h0000_4000, '0, 32'hFFFF_C000);
        send_word(REQ_GYRO, NEG_FULL, NEG_FULL, NEG_FULL);
        settle_block();

        for (int phase = 1; phase <= 4; phase++) begin
            case (phase)
                1: begin
                    accel_word = 32'hFFFF_0000;
                    magnet_word = 32'h5A5A_FFFF;
                end
                2: begin
                    accel_word = 32'hFFFF_FFFF;
                    magnet_word = 32'h0001_0000;
                end
                default: begin
                    accel_word = $urandom();
                    magnet_word = $urandom();
                end
            endcase
            set_gains(1'b1, accel_word, magnet_word);
            src_steady = (phase == 2) || (phase == 4);
            sink_steady = (phase == 4);
            hold_pending = (phase == 2);
            repeat (PHASE_WORDS) begin
                send_word(pick_kind(), pick_component(), pick_component(), pick_component());
            end
            settle_block();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("PASS attitude_vector_observer");
        end else begin
            $display("FAIL attitude_vector_observer");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/avo_pkg.sv
hdl/avo_ctrl.sv
hdl/avo_datapath.sv
hdl/attitude_vector_observer.sv
tb/sv/avo_result_check.sv
tb/sv/tb.sv
